// ===== hdl/ghsp_pkg.sv =====
// ghsp_pkg: payload structs, action and status codes for the handle slot pool.
// No dependencies; ghsp_alloc, the top level and ghsp_checker refer to it by scoped names.

package ghsp_pkg;

   // fixed field widths of the request and response beats
   localparam int IDX_W     = 8;
   localparam int IDX_DEPTH = 2 ** IDX_W;
   localparam int HGEN_W    = 8;
   localparam int OIDX_W    = 6;
   localparam int OGEN_W    = 8;

   // action codes (code 3 behaves as a lookup)
   localparam logic [1:0] ACT_CREATE  = 2'd0;
   localparam logic [1:0] ACT_RELEASE = 2'd1;
   localparam logic [1:0] ACT_LOOKUP  = 2'd2;

   // status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_NOT_OPEN = 3'd2;
   localparam logic [2:0] ST_NOT_USED = 3'd3;
   localparam logic [2:0] ST_STALE    = 3'd4;

   typedef struct packed {
      logic [1:0]        action;
      logic [IDX_W-1:0]  slot_index;
      logic [HGEN_W-1:0] handle_generation;
   } req_type;

   typedef struct packed {
      logic [OIDX_W-1:0] granted_index;
      logic [OGEN_W-1:0] granted_generation;
      logic [2:0]        status;
   } rsp_type;

   // allocator decision flags
   typedef struct packed {
      logic full;   // table at full size and every slot in use
      logic grow;   // no free open slot, open size must grow
   } alloc_flags_type;

endpackage

// ===== hdl/ghsp_ram.sv =====
// ghsp_ram: generic simple dual-port RAM, one write and one registered read port.
// Read-before-write on a same-address collision. No dependencies.

module ghsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ghsp_alloc.sv =====
// ghsp_alloc: free-slot priority encoder and open-size growth for create.
// Depends on ghsp_pkg (alloc_flags_type).

module ghsp_alloc #(
   parameter int SLOTS = 64
) (
   input  logic [SLOTS-1:0]           used,
   input  logic [$clog2(SLOTS+1)-1:0] open_size,
   output logic [$clog2(SLOTS)-1:0]   pick,
   output logic [$clog2(SLOTS+1)-1:0] grown,
   output ghsp_pkg::alloc_flags_type  flags
);

   localparam int AW = $clog2(SLOTS);
   localparam int OW = $clog2(SLOTS+1);

   logic [SLOTS-1:0] free_slots;
   logic             found;
   logic [AW-1:0]    first_free;
   logic [OW:0]      grow_sum;

   // a slot is free when it is open and not in use
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         free_slots[i] = !used[i] && (OW'(i) < open_size);
      end
   end

   // lowest free slot
   always_comb begin
      found      = 1'b0;
      first_free = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (free_slots[i]) begin
            found      = 1'b1;
            first_free = AW'(i);
         end
      end
   end

   // size + size/2 + 1, capped at the table size
   always_comb begin
      grow_sum = {1'b0, open_size} + (OW+1)'(open_size >> 1) + (OW+1)'(1);
      if (grow_sum > (OW+1)'(SLOTS)) begin
         grown = OW'(SLOTS);
      end else begin
         grown = grow_sum[OW-1:0];
      end
   end

   assign flags.full = !found && (open_size == OW'(SLOTS));
   assign flags.grow = !found && (open_size != OW'(SLOTS));
   assign pick       = found ? first_free : AW'(open_size);

endmodule

// ===== hdl/generational_handle_slot_pool.sv =====
// generational_handle_slot_pool: top level, request register stage, result logic.
// Depends on ghsp_pkg, ghsp_alloc and ghsp_ram.
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+------------------------------
//   req     | in  | req_valid/req_ready | ghsp_pkg::req_type req_data
//   rsp     | out | rsp_valid/rsp_ready | ghsp_pkg::rsp_type rsp_data
//
// One request per cycle unless rsp stalls; each response passes the request stage
// and output register. Slot pick and generation RAM read happen at accept, using
// the state left by the request ahead; the result uses the RAM data next cycle.
// Longest path: release generation compare -> used flags -> priority encoder
// -> RAM read address. Reset is synchronous; no clearing pass, a fill count
// makes never-written generations read as zero. A stalled rsp holds one beat
// in the output register and one in the request stage before req_ready drops.

module generational_handle_slot_pool #(
   parameter int SLOTS    = 64,
   parameter int GEN_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ghsp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ghsp_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(SLOTS);
   localparam int OW = $clog2(SLOTS+1);
   localparam int CW = (OW > ghsp_pkg::IDX_W) ? OW : ghsp_pkg::IDX_W;

   // slot state
   logic [SLOTS-1:0] used_ff, used_in;
   logic [OW-1:0]    open_ff, open_in;
   logic [OW-1:0]    fill_ff, fill_in;

   // request stage
   logic                      s1_valid_ff, s1_valid_in;
   logic [1:0]                s1_action_ff;
   logic [ghsp_pkg::IDX_W-1:0] s1_idx_ff;
   logic [GEN_BITS-1:0]       s1_gen_ff;
   logic [AW-1:0]             s1_addr_ff;
   logic                      s1_full_ff;
   logic                      s1_grow_ff;
   logic [OW-1:0]             s1_grown_ff;
   logic                      s1_fwd_ff;
   logic [GEN_BITS-1:0]       s1_fwd_gen_ff;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   ghsp_pkg::rsp_type rsp_data_ff, rsp_next;

   // handshake
   logic advance, commit, accept;

   // allocator and RAM
   logic [AW-1:0]             alloc_pick;
   logic [OW-1:0]             alloc_grown;
   ghsp_pkg::alloc_flags_type alloc_flags;
   logic [AW-1:0]             rd_addr;
   logic [GEN_BITS-1:0]       ram_rd_data;
   logic                      wr_req;
   logic                      set_used, clr_used;

   // result stage signals
   logic [GEN_BITS-1:0]        gen_cur, new_gen;
   logic                       unwritten, idx_open, gen_match;
   logic [ghsp_pkg::OIDX_W-1:0] echo_tab [ghsp_pkg::IDX_DEPTH];

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign commit    = s1_valid_ff && advance;
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   // index modulo table size, worked out at elaboration
   for (genvar v = 0; v < ghsp_pkg::IDX_DEPTH; v++) begin : g_echo
      assign echo_tab[v] = ghsp_pkg::OIDX_W'(v % SLOTS);
   end

   // current generation: forwarded write, never written, or RAM data
   assign unwritten = OW'(s1_addr_ff) >= fill_ff;
   assign gen_cur   = s1_fwd_ff ? s1_fwd_gen_ff :
                      (unwritten ? '0 : ram_rd_data);
   assign new_gen   = gen_cur + GEN_BITS'(1);
   assign idx_open  = CW'(s1_idx_ff) < CW'(open_ff);
   assign gen_match = gen_cur == s1_gen_ff;

   // result and state update for the request in the stage
   always_comb begin
      wr_req   = 1'b0;
      set_used = 1'b0;
      clr_used = 1'b0;
      rsp_next.granted_index      = echo_tab[s1_idx_ff];
      rsp_next.granted_generation = '0;
      rsp_next.status             = ghsp_pkg::ST_OK;
      if (s1_action_ff == ghsp_pkg::ACT_CREATE) begin
         if (s1_full_ff) begin
            rsp_next.granted_index = '0;
            rsp_next.status        = ghsp_pkg::ST_FULL;
         end else begin
            wr_req   = 1'b1;
            set_used = 1'b1;
            rsp_next.granted_index      = ghsp_pkg::OIDX_W'(s1_addr_ff);
            rsp_next.granted_generation = ghsp_pkg::OGEN_W'(new_gen);
         end
      end else if (!idx_open) begin
         rsp_next.status = ghsp_pkg::ST_NOT_OPEN;
      end else if (s1_action_ff == ghsp_pkg::ACT_RELEASE) begin
         if (!used_ff[s1_addr_ff]) begin
            rsp_next.status = ghsp_pkg::ST_NOT_USED;
         end else if (!gen_match) begin
            rsp_next.status = ghsp_pkg::ST_STALE;
         end else begin
            clr_used = 1'b1;
         end
      end else if (!gen_match) begin
         rsp_next.status = ghsp_pkg::ST_STALE;
      end
   end

   // next slot state, also seen by the allocator for the next request
   always_comb begin
      used_in = used_ff;
      if (commit && set_used) begin
         used_in[s1_addr_ff] = 1'b1;
      end
      if (commit && clr_used) begin
         used_in[s1_addr_ff] = 1'b0;
      end
   end

   assign open_in = (commit && set_used && s1_grow_ff) ? s1_grown_ff : open_ff;
   assign fill_in = (commit && set_used && (OW'(s1_addr_ff) == fill_ff)) ?
                    fill_ff + OW'(1) : fill_ff;

   ghsp_alloc #(
      .SLOTS(SLOTS)
   ) u_alloc (
      .used      (used_in),
      .open_size (open_in),
      .pick      (alloc_pick),
      .grown     (alloc_grown),
      .flags     (alloc_flags)
   );

   assign rd_addr = (req_data.action == ghsp_pkg::ACT_CREATE) ? alloc_pick :
                    AW'(req_data.slot_index);

   ghsp_ram #(
      .WIDTH(GEN_BITS),
      .DEPTH(SLOTS)
   ) u_gen_ram (
      .clock   (clock),
      .wr_en   (commit && wr_req),
      .wr_addr (s1_addr_ff),
      .wr_data (new_gen),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   assign s1_valid_in  = accept || (s1_valid_ff && !commit);
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
         open_ff      <= '0;
         fill_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         used_ff      <= used_in;
         open_ff      <= open_in;
         fill_ff      <= fill_in;
      end
   end

   // request stage and output payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_action_ff  <= req_data.action;
         s1_idx_ff     <= req_data.slot_index;
         s1_gen_ff     <= GEN_BITS'(req_data.handle_generation);
         s1_addr_ff    <= rd_addr;
         s1_full_ff    <= alloc_flags.full;
         s1_grow_ff    <= alloc_flags.grow;
         s1_grown_ff   <= alloc_grown;
         s1_fwd_ff     <= commit && wr_req && (rd_addr == s1_addr_ff);
         s1_fwd_gen_ff <= new_gen;
      end
      if (commit) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/ghsp_checker.sv =====
// ghsp_checker: port-level assertions for the handle slot pool, bound to the top.
// Depends on ghsp_pkg and generational_handle_slot_pool.

module ghsp_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ghsp_pkg::rsp_type rsp_data
);

   // a stalled response beat stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("rsp payload changed while stalled");

   // a beat whose status is not OK carries generation zero
   a_gen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ghsp_pkg::ST_OK) |->
      rsp_data.granted_generation == '0)
      else $error("generation on a failed beat");

   // pool full reports index zero
   a_full_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ghsp_pkg::ST_FULL) |->
      rsp_data.granted_index == '0)
      else $error("pool full with non-zero index");

   // nothing comes out straight after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind generational_handle_slot_pool ghsp_checker u_checker (.*);
